### hw/rtl/cape_pkg.sv
// cape_pkg: shared types, constants and the age palette for the cell pixel expander.
// Used by every module under hw/rtl; depends on nothing.
`default_nettype none
package cape_pkg;

    localparam int PIXEL_BLOCK = 4;
    localparam int BOARD_COLS  = 256;
    localparam int BOARD_ROWS  = 256;
    localparam int FRAME_WIDTH = 1024;

    localparam int ADDR_W    = 20;
    localparam int COLOUR_W  = 24;
    localparam int NUM_W     = 16;
    localparam int DIV_CELLS = NUM_W;
    localparam int DIM_W     = (PIXEL_BLOCK > 1) ? $clog2(PIXEL_BLOCK) : 1;
    localparam int PADDR_W   = 5;

    localparam logic [ADDR_W-1:0] ROW_STRIDE =
        ADDR_W'((PIXEL_BLOCK * FRAME_WIDTH) % (1 << ADDR_W));
    localparam logic [ADDR_W-1:0] LINE_STEP = ADDR_W'(FRAME_WIDTH % (1 << ADDR_W));
    localparam logic [DIM_W-1:0]  DIM_LAST  = DIM_W'(PIXEL_BLOCK - 1);

    localparam logic [COLOUR_W-1:0] WHITE = 24'hFFFFFF;
    localparam logic [COLOUR_W-1:0] BLACK = 24'h000000;

    typedef enum logic [2:0] {
        REG_PALETTE = 3'd0,
        REG_SMOOTH  = 3'd1,
        REG_ALIVE   = 3'd2,
        REG_DEAD    = 3'd3,
        REG_DIVISOR = 3'd4
    } cape_reg_t;

    typedef struct packed {
        logic       palette;
        logic       smooth;
        logic [7:0] live_bias;
        logic [7:0] dead_bias;
        logic [7:0] divisor;
    } cape_cfg_t;

    typedef struct packed {
        logic             valid;
        logic             drop;
        logic             alive;
        logic [7:0]       col;
        logic [7:0]       row;
        logic [8:0]       level;
        logic [7:0]       rem;
        logic [NUM_W-1:0] work;
    } cape_word_t;

    localparam logic [COLOUR_W-1:0] AGE_ROM [256] = '{
        24'h000000, 24'h070000, 24'h0F0000, 24'h170000,
        24'h1F0000, 24'h270000, 24'h2F0000, 24'h370000,
        24'h3F0000, 24'h470000, 24'h4F0000, 24'h570000,
        24'h5F0000, 24'h670000, 24'h6F0000, 24'h770000,
        24'h7F0000, 24'h870000, 24'h8F0000, 24'h970000,
        24'h9F0000, 24'hA70000, 24'hAF0000, 24'hB70000,
        24'hBF0000, 24'hC70000, 24'hCF0000, 24'hD70000,
        24'hDF0000, 24'hE70000, 24'hEF0000, 24'hF70000,
        24'hFF0000, 24'hFF0007, 24'hFF000F, 24'hFF0017,
        24'hFF001F, 24'hFF0027, 24'hFF002F, 24'hFF0037,
        24'hFF003F, 24'hFF0047, 24'hFF004F, 24'hFF0057,
        24'hFF005F, 24'hFF0067, 24'hFF006F, 24'hFF0077,
        24'hFF007F, 24'hFF0087, 24'hFF008F, 24'hFF0097,
        24'hFF009F, 24'hFF00A7, 24'hFF00AF, 24'hFF00B7,
        24'hFF00BF, 24'hFF00C7, 24'hFF00CF, 24'hFF00D7,
        24'hFF00DF, 24'hFF00E7, 24'hFF00EF, 24'hFF00F7,
        24'hFF00FF, 24'hF700FF, 24'hEF00FF, 24'hE700FF,
        24'hDF00FF, 24'hD700FF, 24'hCF00FF, 24'hC700FF,
        24'hBF00FF, 24'hB700FF, 24'hAF00FF, 24'hA700FF,
        24'h9F00FF, 24'h9700FF, 24'h8F00FF, 24'h8700FF,
        24'h7F00FF, 24'h7700FF, 24'h6F00FF, 24'h6700FF,
        24'h5F00FF, 24'h5700FF, 24'h4F00FF, 24'h4700FF,
        24'h3F00FF, 24'h3700FF, 24'h2F00FF, 24'h2700FF,
        24'h1F00FF, 24'h1700FF, 24'h0F00FF, 24'h0700FF,
        24'h0000FF, 24'h0007FF, 24'h000FFF, 24'h0017FF,
        24'h001FFF, 24'h0027FF, 24'h002FFF, 24'h0037FF,
        24'h003FFF, 24'h0047FF, 24'h004FFF, 24'h0057FF,
        24'h005FFF, 24'h0067FF, 24'h006FFF, 24'h0077FF,
        24'h007FFF, 24'h0087FF, 24'h008FFF, 24'h0097FF,
        24'h009FFF, 24'h00A7FF, 24'h00AFFF, 24'h00B7FF,
        24'h00BFFF, 24'h00C7FF, 24'h00CFFF, 24'h00D7FF,
        24'h00DFFF, 24'h00E7FF, 24'h00EFFF, 24'h00F7FF,
        24'h00FFFF, 24'h00FFF7, 24'h00FFEF, 24'h00FFE7,
        24'h00FFDF, 24'h00FFD7, 24'h00FFCF, 24'h00FFC7,
        24'h00FFBF, 24'h00FFB7, 24'h00FFAF, 24'h00FFA7,
        24'h00FF9F, 24'h00FF97, 24'h00FF8F, 24'h00FF87,
        24'h00FF7F, 24'h00FF77, 24'h00FF6F, 24'h00FF67,
        24'h00FF5F, 24'h00FF57, 24'h00FF4F, 24'h00FF47,
        24'h00FF3F, 24'h00FF37, 24'h00FF2F, 24'h00FF27,
        24'h00FF1F, 24'h00FF17, 24'h00FF0F, 24'h00FF07,
        24'h00FF00, 24'h07FF00, 24'h0FFF00, 24'h17FF00,
        24'h1FFF00, 24'h27FF00, 24'h2FFF00, 24'h37FF00,
        24'h3FFF00, 24'h47FF00, 24'h4FFF00, 24'h57FF00,
        24'h5FFF00, 24'h67FF00, 24'h6FFF00, 24'h77FF00,
        24'h7FFF00, 24'h87FF00, 24'h8FFF00, 24'h97FF00,
        24'h9FFF00, 24'hA7FF00, 24'hAFFF00, 24'hB7FF00,
        24'hBFFF00, 24'hC7FF00, 24'hCFFF00, 24'hD7FF00,
        24'hDFFF00, 24'hE7FF00, 24'hEFFF00, 24'hF7FF00,
        24'hFFFF00, 24'hFFFB00, 24'hFFF800, 24'hFFF400,
        24'hFFF100, 24'hFFED00, 24'hFFEA00, 24'hFFE700,
        24'hFFE300, 24'hFFE000, 24'hFFDC00, 24'hFFD901,
        24'hFFD601, 24'hFFD201, 24'hFFCF01, 24'hFFCB01,
        24'hFFC801, 24'hFFC501, 24'hFFC101, 24'hFFBE01,
        24'hFFBA01, 24'hFFB701, 24'hFFB402, 24'hFFB002,
        24'hFFAD02, 24'hFFA902, 24'hFFA602, 24'hFFA302,
        24'hFF9F02, 24'hFF9C02, 24'hFF9802, 24'hFF9502,
        24'hFF9203, 24'hF68D02, 24'hEE8802, 24'hE68302,
        24'hDE7F02, 24'hD57A02, 24'hCD7502, 24'hC57102,
        24'hBD6C02, 24'hB46702, 24'hAC6202, 24'hA45E01,
        24'h9C5901, 24'h945401, 24'h8B5001, 24'h834B01,
        24'h7B4601, 24'h734101, 24'h6A3D01, 24'h623801,
        24'h5A3301, 24'h522F00, 24'h4A2A00, 24'h412500,
        24'h392000, 24'h311C00, 24'h291700, 24'h201200,
        24'h180E00, 24'h100900, 24'h080400, 24'h000000
    };

endpackage
`default_nettype wire

### hw/rtl/cape_cfg.sv
// cape_cfg: APB-style register file for the mode, offsets and palette divisor.
// Depends on cape_pkg.
`default_nettype none
module cape_cfg (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [cape_pkg::PADDR_W-1:0]  paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready,
    output cape_pkg::cape_cfg_t           cfg
);
    import cape_pkg::*;

    logic       palette_reg;
    logic       smooth_reg;
    logic [7:0] alive_reg;
    logic [7:0] dead_reg;
    logic [7:0] divisor_reg;
    logic       wr_en;
    cape_reg_t  idx;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;
    assign idx    = cape_reg_t'(paddr[PADDR_W-1:2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            palette_reg <= 1'b0;
            smooth_reg  <= 1'b0;
            alive_reg   <= 8'd0;
            dead_reg    <= 8'd0;
            divisor_reg <= 8'd1;
        end
        else if (wr_en)
        begin
            unique case (idx)
                REG_PALETTE: palette_reg <= pwdata[0];
                REG_SMOOTH:  smooth_reg  <= pwdata[0];
                REG_ALIVE:   alive_reg   <= pwdata[7:0];
                REG_DEAD:    dead_reg    <= pwdata[7:0];
                REG_DIVISOR: divisor_reg <= pwdata[7:0];
                default:     ;
            endcase
        end
    end

    always_comb
    begin
        unique case (idx)
            REG_PALETTE: prdata = {31'd0, palette_reg};
            REG_SMOOTH:  prdata = {31'd0, smooth_reg};
            REG_ALIVE:   prdata = {24'd0, alive_reg};
            REG_DEAD:    prdata = {24'd0, dead_reg};
            REG_DIVISOR: prdata = {24'd0, divisor_reg};
            default:     prdata = 32'd0;
        endcase
    end

    // zero divisor acts as one
    assign cfg.palette   = palette_reg;
    assign cfg.smooth    = smooth_reg;
    assign cfg.live_bias = alive_reg;
    assign cfg.dead_bias = dead_reg;
    assign cfg.divisor   = (divisor_reg == 8'd0) ? 8'd1 : divisor_reg;

endmodule
`default_nettype wire

### hw/rtl/cape_div_cell.sv
// cape_div_cell: one restoring-division step; shifts one quotient bit into the word.
// Depends on cape_pkg.
`default_nettype none
module cape_div_cell (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 advance,
    input  logic [7:0]           divisor,
    input  cape_pkg::cape_word_t word_in,
    output cape_pkg::cape_word_t word_out
);
    import cape_pkg::*;

    logic       valid_reg;
    cape_word_t word_reg;
    cape_word_t word_next;
    logic [8:0] shifted;
    logic       ge;

    always_comb
    begin
        shifted   = {word_in.rem, word_in.work[NUM_W-1]};
        ge        = shifted >= {1'b0, divisor};
        word_next = word_in;
        word_next.rem  = ge ? 8'(shifted - {1'b0, divisor}) : shifted[7:0];
        word_next.work = {word_in.work[NUM_W-2:0], ge};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            valid_reg <= word_in.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            word_reg <= word_next;
        end
    end

    always_comb
    begin
        word_out       = word_reg;
        word_out.valid = valid_reg;
    end

endmodule
`default_nettype wire

### hw/rtl/cape_emitter.sv
// cape_emitter: final colour pick and the square of pixel writes for one cell.
// Depends on cape_pkg.
`default_nettype none
module cape_emitter (
    input  logic                          clk,
    input  logic                          rst_n,
    input  cape_pkg::cape_cfg_t           cfg,
    input  cape_pkg::cape_word_t          word_in,
    output logic                          free,
    output logic                          strobe,
    output logic [cape_pkg::ADDR_W-1:0]   pixel_address,
    output logic [cape_pkg::COLOUR_W-1:0] pixel_color,
    output logic                          last_pixel
);
    import cape_pkg::*;

    logic                active_reg;
    logic [DIM_W-1:0]    dx_reg;
    logic [DIM_W-1:0]    dy_reg;
    logic [ADDR_W-1:0]   addr_reg;
    logic [ADDR_W-1:0]   col_addr_reg;
    logic [COLOUR_W-1:0] colour_reg;

    logic                load;
    logic                last;
    logic [16:0]         grey_prod;
    logic [7:0]          grey;
    logic [COLOUR_W-1:0] colour;
    logic [ADDR_W-1:0]   base;

    assign last = (dx_reg == DIM_LAST) && (dy_reg == DIM_LAST);
    assign free = !active_reg || last;
    assign load = word_in.valid && !word_in.drop && free;

    always_comb
    begin
        grey_prod = 17'(word_in.level) * 17'd255;
        grey      = (grey_prod[16:8] > 9'd255) ? 8'd255 : grey_prod[15:8];
        if (cfg.palette)
        begin
            colour = AGE_ROM[word_in.work[7:0]];
        end
        else if (cfg.smooth)
        begin
            colour = {grey, grey, grey};
        end
        else
        begin
            colour = word_in.alive ? WHITE : BLACK;
        end
        base = ADDR_W'(28'(word_in.row) * 28'(ROW_STRIDE))
             + ADDR_W'(ADDR_W'(word_in.col) * ADDR_W'(PIXEL_BLOCK));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
        end
        else if (load)
        begin
            active_reg <= 1'b1;
        end
        else if (last)
        begin
            active_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            dx_reg       <= '0;
            dy_reg       <= '0;
            addr_reg     <= base;
            col_addr_reg <= base;
            colour_reg   <= colour;
        end
        else if (active_reg && !last)
        begin
            if (dy_reg == DIM_LAST)
            begin
                dy_reg       <= '0;
                dx_reg       <= dx_reg + 1'b1;
                col_addr_reg <= col_addr_reg + 1'b1;
                addr_reg     <= col_addr_reg + 1'b1;
            end
            else
            begin
                dy_reg   <= dy_reg + 1'b1;
                addr_reg <= addr_reg + LINE_STEP;
            end
        end
    end

    assign strobe        = active_reg;
    assign pixel_address = addr_reg;
    assign pixel_color   = colour_reg;
    assign last_pixel    = active_reg && last;

`ifndef ASSERT_OFF
    a_burst_unbroken: assert property (@(posedge clk) disable iff (!rst_n)
        (active_reg && !last) |=> active_reg)
        else $error("pixel burst broken before last word");

    a_colour_held: assert property (@(posedge clk) disable iff (!rst_n)
        (active_reg && !last) |=> $stable(colour_reg))
        else $error("colour changed inside a burst");

    a_load_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        load |-> (!active_reg || last_pixel))
        else $error("new cell loaded over a running burst");

    a_restart_origin: assert property (@(posedge clk) disable iff (!rst_n)
        load |=> (dx_reg == '0 && dy_reg == '0))
        else $error("burst did not start at square origin");
`endif

endmodule
`default_nettype wire

### hw/rtl/cell_age_palette_pixel_expander.sv
// cell_age_palette_pixel_expander: a cell word enters, its palette index runs down a
// chain of 16 division cells, then the emitter writes a PIXEL_BLOCK square of pixels.
// Each word is registered in every division cell and then in the emitter; one pixel word per cycle.
// The emitter takes a new cell only when idle or on the last pixel word of its square.
// busy rises only when a finished cell waits at the chain tail for the emitter.
// Reset: asynchronous, clears all valid bits and loads register defaults.
`default_nettype none
module cell_age_palette_pixel_expander (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [7:0]                    cell_col,
    input  logic [7:0]                    cell_row,
    input  logic signed [15:0]            cell_age,
    input  logic [8:0]                    cell_level,
    output logic                          strobe,
    output logic [cape_pkg::ADDR_W-1:0]   pixel_address,
    output logic [cape_pkg::COLOUR_W-1:0] pixel_color,
    output logic                          last_pixel,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [cape_pkg::PADDR_W-1:0]  paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);
    import cape_pkg::*;

    cape_cfg_t  cfg;
    cape_word_t chain [DIV_CELLS+1];
    logic       advance;
    logic       free;
    logic       alive;
    logic [16:0] num;

    cape_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    always_comb
    begin
        alive = !cell_age[15] && (cell_age != 16'sd0);
        if (alive)
        begin
            num = 17'({1'b0, cell_age}) + 17'(cfg.live_bias);
        end
        else
        begin
            num = (17'd0 - 17'({cell_age[15], cell_age})) + 17'(cfg.dead_bias);
        end
        chain[0].valid = start;
        chain[0].drop  = (13'(cell_col) >= 13'(BOARD_COLS))
                      || (13'(cell_row) >= 13'(BOARD_ROWS));
        chain[0].alive = alive;
        chain[0].col   = cell_col;
        chain[0].row   = cell_row;
        chain[0].level = cell_level;
        chain[0].rem   = 8'd0;
        chain[0].work  = num[NUM_W-1:0];
    end

    assign advance = !(chain[DIV_CELLS].valid && !chain[DIV_CELLS].drop) || free;
    assign busy    = !advance;

    for (genvar i = 0; i < DIV_CELLS; i++)
    begin : g_cell
        cape_div_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .advance  (advance),
            .divisor  (cfg.divisor),
            .word_in  (chain[i]),
            .word_out (chain[i+1])
        );
    end

    cape_emitter u_emit (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg           (cfg),
        .word_in       (chain[DIV_CELLS]),
        .free          (free),
        .strobe        (strobe),
        .pixel_address (pixel_address),
        .pixel_color   (pixel_color),
        .last_pixel    (last_pixel)
    );

endmodule
`default_nettype wire
